// ===== sv/owrs_pkg.sv =====
// Shared types and codes for the one-wire ROM search engine.
package owrs_pkg;

    // Widths fixed by the search state and the result fields
    localparam int unsigned ROM_W   = 64;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned FAM_W   = 4;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned IDX_W   = $clog2(ROM_W);

    // Request kinds carried on the input tuser
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PAIR  = 2'd2;

    // Status codes carried on the output tuser
    localparam logic [STAT_W-1:0] ST_CONTINUE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE     = 2'd3;

    // Family byte: search bits 1 through 8
    localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0]       FAMILY_MASK  = 8'hFF;

    typedef struct packed {
        logic [ROM_W-1:0] rom;
        logic [POS_W-1:0] last_disc;
        logic [FAM_W-1:0] fam_disc;
        logic             last_dev;
        logic             active;
        logic [POS_W-1:0] bit_pos;
        logic [POS_W-1:0] zero_pos;
    } t_search_state;

    localparam t_search_state SEARCH_RESET = '{
        rom:       '0,
        last_disc: '0,
        fam_disc:  '0,
        last_dev:  1'b0,
        active:    1'b0,
        bit_pos:   7'd1,
        zero_pos:  '0
    };

endpackage

// ===== sv/owrs_step.sv =====
// Next-state and decision logic for one search request.
module owrs_step
    import owrs_pkg::*;
#(
    parameter int unsigned ROM_BITS = 64
) (
    input  t_search_state     i_state,
    input  logic [REQ_W-1:0]  i_req,
    input  logic              i_presence,
    input  logic              i_id_bit,
    input  logic              i_cmp_bit,
    output t_search_state     o_state,
    output logic              o_dir_bit,
    output logic [STAT_W-1:0] o_status
);

    localparam logic [ROM_W-1:0] ROM_MASK = (ROM_BITS >= ROM_W) ? {ROM_W{1'b1}} :
                                            ((ROM_W'(1) << ROM_BITS) - ROM_W'(1));
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_m1;
    logic [IDX_W-1:0] idx;
    logic             dir;
    logic [ROM_W-1:0] rom_next;

    assign pos    = i_state.bit_pos;
    assign pos_m1 = pos - POS_W'(1);
    assign idx    = pos_m1[IDX_W-1:0];

    // Decide the direction bit for the current position
    always_comb begin
        if (i_id_bit != i_cmp_bit) begin
            dir = i_id_bit;
        end else if (pos < i_state.last_disc) begin
            dir = i_state.rom[idx];
        end else begin
            dir = (pos == i_state.last_disc);
        end
    end

    // Write the chosen bit into the ROM code
    always_comb begin
        rom_next      = i_state.rom;
        rom_next[idx] = dir;
        rom_next      = rom_next & ROM_MASK;
    end

    // Update the search state and pick the status
    always_comb begin
        o_state   = i_state;
        o_dir_bit = 1'b0;
        o_status  = ST_IDLE;
        case (i_req)
            REQ_CLEAR: begin
                o_state = SEARCH_RESET;
            end
            REQ_BEGIN: begin
                if (i_state.last_dev || !i_presence) begin
                    o_state.last_disc = '0;
                    o_state.last_dev  = 1'b0;
                    o_state.fam_disc  = '0;
                    o_state.active    = 1'b0;
                    o_status          = ST_NONE;
                end else begin
                    o_state.active    = 1'b1;
                    o_state.bit_pos   = POS_W'(1);
                    o_state.zero_pos  = '0;
                    o_status          = ST_CONTINUE;
                end
            end
            REQ_PAIR: begin
                if (i_state.active) begin
                    if (i_id_bit && i_cmp_bit) begin
                        // no device answered: abandon the pass
                        o_state.last_disc = '0;
                        o_state.last_dev  = 1'b0;
                        o_state.fam_disc  = '0;
                        o_state.active    = 1'b0;
                        o_status          = ST_NONE;
                    end else begin
                        o_dir_bit = dir;
                        o_state.rom = rom_next;
                        if ((i_id_bit == i_cmp_bit) && !dir) begin
                            o_state.zero_pos = pos;
                            if (pos < FAMILY_LIMIT) begin
                                o_state.fam_disc = pos[FAM_W-1:0];
                            end
                        end
                        if (pos >= LAST_POS) begin
                            // close the pass
                            o_state.active    = 1'b0;
                            o_state.bit_pos   = POS_W'(1);
                            o_state.last_disc = o_state.zero_pos;
                            if (o_state.zero_pos == '0) begin
                                o_state.last_dev = 1'b1;
                            end
                            if ((rom_next[7:0] & FAMILY_MASK) == 8'd0) begin
                                o_state.last_disc = '0;
                                o_state.last_dev  = 1'b0;
                                o_state.fam_disc  = '0;
                                o_status          = ST_NONE;
                            end else begin
                                o_status = ST_FOUND;
                            end
                        end else begin
                            o_state.bit_pos = pos + POS_W'(1);
                            o_status        = ST_CONTINUE;
                        end
                    end
                end
            end
            default: begin
                o_status = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/one_wire_rom_search_top.sv =====
// Top level of the one-wire ROM search decision engine.
//
// Usage: each request enters on the slave stream. tuser carries the request
// kind (clear search, begin pass, bit pair); tdata carries the presence flag
// and the two bits read from the bus. The engine answers every request with
// exactly one transfer on the master stream: the direction bit to write, the
// status in tuser, and the current ROM code, family discrepancy and
// last-device flag in tdata.
// Each answer is registered and shows in the cycle after its request is
// accepted. Throughput is one request per cycle while the receiver takes each
// answer; the whole decision and state update sit between the search state
// registers and the output register, so back-to-back bit pairs need no gap.
// A new request is taken while the output register is empty or is being
// drained in the same cycle; when the receiver stalls, the answer holds and
// the input stalls with it, so nothing is lost or repeated.
// Reset empties the output register and returns the search state to its
// cleared values (ROM code zero, bit position one, no pass active).
module one_wire_rom_search_top
    import owrs_pkg::*;
#(
    parameter int unsigned ROM_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [0] presence, [1] id_bit, [2] cmp_bit, [7:3] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // [0] dir_bit, [64:1] rom_code,
                                    // [68:65] family_discrepancy, [69] last_device, [71:70] zero
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    t_search_state     r_state;
    t_search_state     n_state;
    logic              r_out_valid;
    logic              r_out_dir;
    logic [STAT_W-1:0] r_out_status;
    logic              n_dir;
    logic [STAT_W-1:0] n_status;
    logic              s_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    owrs_step #(
        .ROM_BITS(ROM_BITS)
    ) u_step (
        .i_state      (r_state),
        .i_req        (i_s_tuser),
        .i_presence   (i_s_tdata[0]),
        .i_id_bit     (i_s_tdata[1]),
        .i_cmp_bit    (i_s_tdata[2]),
        .o_state      (n_state),
        .o_dir_bit    (n_dir),
        .o_status     (n_status)
    );

    // Advance the search state on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEARCH_RESET;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // Hold the answer until the receiver takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the answer payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_dir    <= n_dir;
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_state.last_dev, r_state.fam_disc, r_state.rom, r_out_dir};

    // A clear request answers idle with an empty ROM code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == REQ_CLEAR) |=>
            o_m_tvalid && (o_m_tuser == ST_IDLE) && (o_m_tdata[64:1] == '0))
        else $error("clear request did not return to cleared state");

    // A closed pass leaves no pass running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == ST_FOUND) || (o_m_tuser == ST_NONE)) |->
            !r_state.active)
        else $error("pass still active after it was closed");

    // An idle answer never writes a bit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> (o_m_tuser != ST_IDLE))
        else $error("direction bit set on an idle answer");

    // The bit position stays within the ROM code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bit_pos >= POS_W'(1)) && (r_state.bit_pos <= POS_W'(ROM_BITS)))
        else $error("bit position out of range");

    // The last device is only flagged when no discrepancy remains
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.last_dev |-> (r_state.last_disc == '0))
        else $error("last device flagged with a pending discrepancy");

endmodule
